>>> rtl/acmc_pkg.sv
// Package: sizes, memory port structs and address helper for the match counter.
package acmc_pkg;
   localparam int NODES     = 4096;
   localparam int ALPHA     = 26;
   localparam int NODE_W    = 12;
   localparam int SYM_W     = 5;
   localparam int CNT_W     = 16;
   localparam int NU_W      = 13;
   localparam int GADDR_W   = 17;
   localparam int GOTO_DEPTH = NODES * ALPHA;

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_BUILD   = 2'd2;
   localparam logic [1:0] MODE_TEXT    = 2'd3;

   typedef struct packed {
      logic                goto_we;
      logic [NODE_W-1:0]   goto_row;
      logic [SYM_W-1:0]    goto_col;
      logic [NODE_W-1:0]   goto_wd;
      logic                fail_we;
      logic [NODE_W-1:0]   fail_addr;
      logic [NODE_W-1:0]   fail_wd;
      logic                par_we;
      logic [NODE_W-1:0]   par_addr;
      logic [NODE_W-1:0]   par_wd;
      logic                end_we;
      logic [NODE_W-1:0]   end_addr;
      logic [CNT_W-1:0]    end_wd;
      logic                q_we;
      logic [NODE_W-1:0]   q_addr;
      logic [NODE_W-1:0]   q_wd;
   } mem_req_type;

   typedef struct packed {
      logic [NODE_W-1:0]   goto_rd;
      logic [NODE_W-1:0]   fail_rd;
      logic [NODE_W-1:0]   par_rd;
      logic [CNT_W-1:0]    end_rd;
      logic [NODE_W-1:0]   q_rd;
   } mem_rsp_type;

   function automatic logic [GADDR_W-1:0] goto_addr(input logic [NODE_W-1:0] row,
                                                    input logic [SYM_W-1:0] col);
      goto_addr = GADDR_W'(row) * GADDR_W'(ALPHA) + GADDR_W'(col);
   endfunction
endpackage

>>> rtl/acmc_store.sv
// Trie storage: goto table, failure, parent, end count and BFS queue memories.
module acmc_store (
   input  logic                  clock,
   input  acmc_pkg::mem_req_type req,
   output acmc_pkg::mem_rsp_type rsp
);
   logic [acmc_pkg::NODE_W-1:0] goto_mem [acmc_pkg::GOTO_DEPTH];
   logic [acmc_pkg::NODE_W-1:0] fail_mem [acmc_pkg::NODES];
   logic [acmc_pkg::NODE_W-1:0] par_mem  [acmc_pkg::NODES];
   logic [acmc_pkg::CNT_W-1:0]  end_mem  [acmc_pkg::NODES];
   logic [acmc_pkg::NODE_W-1:0] q_mem    [acmc_pkg::NODES];
   logic [acmc_pkg::GADDR_W-1:0] gaddr;

   assign gaddr = acmc_pkg::goto_addr(req.goto_row, req.goto_col);

   always_ff @(posedge clock) begin
      if (req.goto_we) begin
         goto_mem[gaddr] <= req.goto_wd;
      end
      rsp.goto_rd <= goto_mem[gaddr];
      if (req.fail_we) begin
         fail_mem[req.fail_addr] <= req.fail_wd;
      end
      rsp.fail_rd <= fail_mem[req.fail_addr];
      if (req.par_we) begin
         par_mem[req.par_addr] <= req.par_wd;
      end
      rsp.par_rd <= par_mem[req.par_addr];
      if (req.end_we) begin
         end_mem[req.end_addr] <= req.end_wd;
      end
      rsp.end_rd <= end_mem[req.end_addr];
      if (req.q_we) begin
         q_mem[req.q_addr] <= req.q_wd;
      end
      rsp.q_rd <= q_mem[req.q_addr];
   end
endmodule

>>> rtl/acmc_seq.sv
// Sequencer: clear, pattern insert, breadth-first link build and text walk over the store.
module acmc_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  mode,
   input  logic [acmc_pkg::SYM_W-1:0]  sym,
   input  logic                        last,
   output logic                        idle,
   input  logic                        emit_free,
   output logic                        emit_valid,
   output logic [acmc_pkg::CNT_W-1:0]  emit_data,
   output acmc_pkg::mem_req_type       mreq,
   input  acmc_pkg::mem_rsp_type       mrsp
);
   localparam logic [4:0] ST_INIT  = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] P_RD     = 5'd2;
   localparam logic [4:0] P_CH     = 5'd3;
   localparam logic [4:0] P_EV     = 5'd4;
   localparam logic [4:0] P_ZERO   = 5'd5;
   localparam logic [4:0] P_LINK   = 5'd6;
   localparam logic [4:0] P_DONE   = 5'd7;
   localparam logic [4:0] P_INC    = 5'd8;
   localparam logic [4:0] B_HEAD   = 5'd9;
   localparam logic [4:0] B_U      = 5'd10;
   localparam logic [4:0] B_F      = 5'd11;
   localparam logic [4:0] B_RC     = 5'd12;
   localparam logic [4:0] B_C      = 5'd13;
   localparam logic [4:0] B_EV     = 5'd14;
   localparam logic [4:0] T_RD     = 5'd15;
   localparam logic [4:0] T_NX     = 5'd16;
   localparam logic [4:0] T_WALK   = 5'd17;
   localparam logic [4:0] T_ACC    = 5'd18;
   localparam logic [4:0] T_END    = 5'd19;

   localparam logic [acmc_pkg::SYM_W-1:0] COL_LAST = acmc_pkg::SYM_W'(acmc_pkg::ALPHA - 1);
   localparam logic [acmc_pkg::NU_W-1:0]  NU_MAX   = acmc_pkg::NU_W'(acmc_pkg::NODES);

   logic [4:0]                   state_ff, state_in;
   logic [acmc_pkg::NU_W-1:0]    nu_ff, nu_in;
   logic [acmc_pkg::NODE_W-1:0]  pc_ff, pc_in, tc_ff, tc_in, v_ff, v_in;
   logic [acmc_pkg::NODE_W-1:0]  c_ff, c_in, u_ff, u_in, f_ff, f_in;
   logic [acmc_pkg::NU_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [acmc_pkg::SYM_W-1:0]   col_ff, col_in, sym_ff, sym_in;
   logic                         last_ff, last_in, drop_ff, drop_in;
   logic [acmc_pkg::CNT_W-1:0]   total_ff, total_in;
   logic                         child;
   logic [acmc_pkg::NODE_W-1:0]  g;
   logic [acmc_pkg::CNT_W:0]     sum;
   logic [acmc_pkg::CNT_W:0]     inc;

   assign idle = (state_ff == ST_IDLE);
   assign g    = (u_ff == '0) ? '0 : mrsp.goto_rd;
   assign sum  = {1'b0, total_ff} + {1'b0, mrsp.end_rd};
   assign inc  = {1'b0, mrsp.end_rd} + (acmc_pkg::CNT_W+1)'(1);

   always_comb begin
      child = 1'b0;
      if (state_ff == P_EV) begin
         child = (c_ff != '0) && ({1'b0, c_ff} < nu_ff) && (mrsp.par_rd == pc_ff);
      end else begin
         child = (c_ff != '0) && ({1'b0, c_ff} < nu_ff) && (mrsp.par_rd == u_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      nu_in    = nu_ff;
      pc_in    = pc_ff;
      tc_in    = tc_ff;
      v_in     = v_ff;
      c_in     = c_ff;
      u_in     = u_ff;
      f_in     = f_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      col_in   = col_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      drop_in  = drop_ff;
      total_in = total_ff;
      emit_valid = 1'b0;
      emit_data  = total_ff;
      mreq = '0;
      case (state_ff)
         ST_INIT: begin
            mreq.goto_we  = 1'b1;
            mreq.goto_row = '0;
            mreq.goto_col = col_ff;
            if (col_ff == COL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               sym_in  = sym;
               last_in = last;
               case (mode)
                  acmc_pkg::MODE_CLEAR: begin
                     nu_in    = acmc_pkg::NU_W'(1);
                     pc_in    = '0;
                     tc_in    = '0;
                     total_in = '0;
                     drop_in  = 1'b0;
                     col_in   = '0;
                     state_in = ST_INIT;
                  end
                  acmc_pkg::MODE_PATTERN: begin
                     if (drop_ff) begin
                        state_in = P_DONE;
                     end else if (sym >= acmc_pkg::SYM_W'(acmc_pkg::ALPHA)) begin
                        drop_in  = 1'b1;
                        state_in = P_DONE;
                     end else begin
                        state_in = P_RD;
                     end
                  end
                  acmc_pkg::MODE_BUILD: begin
                     mreq.q_we   = 1'b1;
                     mreq.q_addr = '0;
                     mreq.q_wd   = '0;
                     head_in  = '0;
                     tail_in  = acmc_pkg::NU_W'(1);
                     state_in = B_HEAD;
                  end
                  default: begin
                     if (sym >= acmc_pkg::SYM_W'(acmc_pkg::ALPHA)) begin
                        tc_in    = '0;
                        state_in = T_END;
                     end else begin
                        state_in = T_RD;
                     end
                  end
               endcase
            end
         end
         P_RD: begin
            mreq.goto_row = pc_ff;
            mreq.goto_col = sym_ff;
            state_in = P_CH;
         end
         P_CH: begin
            c_in = mrsp.goto_rd;
            mreq.par_addr = mrsp.goto_rd;
            state_in = P_EV;
         end
         P_EV: begin
            if (child) begin
               pc_in    = c_ff;
               state_in = P_DONE;
            end else if (nu_ff < NU_MAX) begin
               col_in   = '0;
               state_in = P_ZERO;
            end else begin
               drop_in  = 1'b1;
               state_in = P_DONE;
            end
         end
         P_ZERO: begin
            mreq.goto_we  = 1'b1;
            mreq.goto_row = nu_ff[acmc_pkg::NODE_W-1:0];
            mreq.goto_col = col_ff;
            if (col_ff == COL_LAST) begin
               state_in = P_LINK;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         P_LINK: begin
            mreq.goto_we   = 1'b1;
            mreq.goto_row  = pc_ff;
            mreq.goto_col  = sym_ff;
            mreq.goto_wd   = nu_ff[acmc_pkg::NODE_W-1:0];
            mreq.fail_we   = 1'b1;
            mreq.fail_addr = nu_ff[acmc_pkg::NODE_W-1:0];
            mreq.par_we    = 1'b1;
            mreq.par_addr  = nu_ff[acmc_pkg::NODE_W-1:0];
            mreq.par_wd    = pc_ff;
            mreq.end_we    = 1'b1;
            mreq.end_addr  = nu_ff[acmc_pkg::NODE_W-1:0];
            pc_in    = nu_ff[acmc_pkg::NODE_W-1:0];
            nu_in    = nu_ff + 1'b1;
            state_in = P_DONE;
         end
         P_DONE: begin
            mreq.end_addr = pc_ff;
            if (last_ff && !drop_ff) begin
               state_in = P_INC;
            end else begin
               if (last_ff) begin
                  pc_in   = '0;
                  drop_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         P_INC: begin
            mreq.end_we   = 1'b1;
            mreq.end_addr = pc_ff;
            mreq.end_wd   = inc[acmc_pkg::CNT_W] ? mrsp.end_rd : inc[acmc_pkg::CNT_W-1:0];
            pc_in    = '0;
            drop_in  = 1'b0;
            state_in = ST_IDLE;
         end
         B_HEAD: begin
            mreq.q_addr = head_ff[acmc_pkg::NODE_W-1:0];
            state_in = (head_ff < tail_ff) ? B_U : ST_IDLE;
         end
         B_U: begin
            u_in = mrsp.q_rd;
            mreq.fail_addr = mrsp.q_rd;
            state_in = B_F;
         end
         B_F: begin
            f_in     = mrsp.fail_rd;
            col_in   = '0;
            state_in = B_RC;
         end
         B_RC: begin
            mreq.goto_row = u_ff;
            mreq.goto_col = col_ff;
            state_in = B_C;
         end
         B_C: begin
            c_in = mrsp.goto_rd;
            mreq.par_addr = mrsp.goto_rd;
            mreq.goto_row = f_ff;
            mreq.goto_col = col_ff;
            state_in = B_EV;
         end
         B_EV: begin
            if (child) begin
               mreq.fail_we   = 1'b1;
               mreq.fail_addr = c_ff;
               mreq.fail_wd   = g;
               if (tail_ff < NU_MAX) begin
                  mreq.q_we   = 1'b1;
                  mreq.q_addr = tail_ff[acmc_pkg::NODE_W-1:0];
                  mreq.q_wd   = c_ff;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               mreq.goto_we  = 1'b1;
               mreq.goto_row = u_ff;
               mreq.goto_col = col_ff;
               mreq.goto_wd  = g;
            end
            if (col_ff == COL_LAST) begin
               head_in  = head_ff + 1'b1;
               state_in = B_HEAD;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = B_RC;
            end
         end
         T_RD: begin
            mreq.goto_row = tc_ff;
            mreq.goto_col = sym_ff;
            state_in = T_NX;
         end
         T_NX: begin
            tc_in = mrsp.goto_rd;
            v_in  = mrsp.goto_rd;
            state_in = T_WALK;
         end
         T_WALK: begin
            mreq.end_addr  = v_ff;
            mreq.fail_addr = v_ff;
            state_in = (v_ff == '0) ? T_END : T_ACC;
         end
         T_ACC: begin
            total_in = sum[acmc_pkg::CNT_W] ? '1 : sum[acmc_pkg::CNT_W-1:0];
            mreq.end_we   = 1'b1;
            mreq.end_addr = v_ff;
            v_in     = mrsp.fail_rd;
            state_in = T_WALK;
         end
         T_END: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (emit_free) begin
               emit_valid = 1'b1;
               total_in   = '0;
               tc_in      = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         nu_ff    <= acmc_pkg::NU_W'(1);
         pc_ff    <= '0;
         tc_ff    <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
         col_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         v_ff     <= '0;
      end else begin
         state_ff <= state_in;
         nu_ff    <= nu_in;
         pc_ff    <= pc_in;
         tc_ff    <= tc_in;
         total_ff <= total_in;
         drop_ff  <= drop_in;
         col_ff   <= col_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         v_ff     <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      u_ff    <= u_in;
      f_ff    <= f_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   a_nu_range: assert property (@(posedge clock) disable iff (reset)
      nu_ff != '0 && nu_ff <= NU_MAX) else $error("node count out of range");
   a_pc_valid: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pc_ff} < nu_ff) else $error("pattern cursor beyond pool");
   a_tc_valid: assert property (@(posedge clock) disable iff (reset)
      {1'b0, tc_ff} < nu_ff) else $error("text cursor beyond pool");
   a_walk_nonroot: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_ACC |-> v_ff != '0) else $error("chain walk visited root");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("bfs head passed tail");
endmodule

>>> rtl/aho_corasick_match_counter.sv
// Top level of the multi-pattern match counter with stream ports and result register.
// The block takes one transaction at a time. Clear runs the same root-row clearing
// pass that runs after reset before the first transaction is accepted. A pattern
// symbol that creates a node also clears the goto row of the new node. A text
// symbol walks every non-root node on its failure chain. Build visits each queued
// node and steps through its 26 letters through the goto memory.
// All step sequences come from the single-port goto memory with registered reads.
module aho_corasick_match_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] symbol, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] match_count
);
   acmc_pkg::mem_req_type mreq;
   acmc_pkg::mem_rsp_type mrsp;
   logic                  idle;
   logic                  emit_valid;
   logic [15:0]           emit_data;
   logic                  emit_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign emit_free  = !rsp_valid_ff || rsp_tready;

   acmc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && idle),
      .mode       (req_tuser),
      .sym        (req_tdata[4:0]),
      .last       (req_tlast),
      .idle       (idle),
      .emit_free  (emit_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .mreq       (mreq),
      .mrsp       (mrsp)
   );

   acmc_store u_store (
      .clock (clock),
      .req   (mreq),
      .rsp   (mrsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

>>> dv/aho_corasick_match_counter_tb.sv
// Testbench for the Aho-Corasick match counter: queued driver, clocked monitor, scoreboard.
module aho_corasick_match_counter_tb;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] symbol;
      logic       last;
   } symbol_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   aho_corasick_match_counter dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [acmc_pkg::NODE_W-1:0] trie_goto [acmc_pkg::NODES*acmc_pkg::ALPHA];
   logic [acmc_pkg::NODE_W-1:0] fail_of [acmc_pkg::NODES];
   logic [acmc_pkg::NODE_W-1:0] parent_of [acmc_pkg::NODES];
   logic [acmc_pkg::CNT_W-1:0]  hits_at [acmc_pkg::NODES];
   int unsigned       node_count, pat_node, txt_node, total;
   bit                pat_dropped;
   logic [acmc_pkg::NODE_W-1:0] walk_q [acmc_pkg::NODES];

   symbol_item_type   pending_items[$];
   logic [15:0]       expected_counts[$];
   int                errors = 0;
   bit                calm = 0;
   bit                send_hold = 0;
   int                rx_hold_cycles = 0;
   int                tx_gap = 0, rx_gap = 0;
   int                stall_cnt = 0;

   function automatic bit true_child(int unsigned node, int unsigned c);
      return c != 0 && c < node_count && parent_of[c] == node;
   endfunction

   task automatic clear_trie();
      for (int i = 0; i < acmc_pkg::NODES*acmc_pkg::ALPHA; i++) trie_goto[i] = '0;
      for (int i = 0; i < acmc_pkg::NODES; i++) begin
         fail_of[i] = '0;
         parent_of[i] = '0;
         hits_at[i] = '0;
      end
      node_count = 1; pat_node = 0; txt_node = 0; total = 0; pat_dropped = 0;
   endtask

   task automatic build_failure_links();
      int unsigned head, tail, u, c, nxt;
      head = 0; tail = 1; walk_q[0] = '0;
      while (head < tail) begin
         u = walk_q[head]; head++;
         for (int j = 0; j < acmc_pkg::ALPHA; j++) begin
            c = trie_goto[u*acmc_pkg::ALPHA+j];
            nxt = (u == 0) ? 0 : trie_goto[fail_of[u]*acmc_pkg::ALPHA+j];
            if (true_child(u, c)) begin
               fail_of[c] = nxt;
               if (tail < acmc_pkg::NODES) begin
                  walk_q[tail] = c; tail++;
               end
            end else begin
               trie_goto[u*acmc_pkg::ALPHA+j] = nxt;
            end
         end
      end
   endtask

   task automatic predict_count(symbol_item_type it);
      int unsigned c, v, steps, n;
      case (it.mode)
         acmc_pkg::MODE_CLEAR: clear_trie();
         acmc_pkg::MODE_PATTERN: begin
            if (!pat_dropped) begin
               if (it.symbol >= acmc_pkg::ALPHA) pat_dropped = 1;
               else begin
                  c = trie_goto[pat_node*acmc_pkg::ALPHA+it.symbol];
                  if (true_child(pat_node, c)) pat_node = c;
                  else if (node_count < acmc_pkg::NODES) begin
                     n = node_count; node_count++;
                     for (int j = 0; j < acmc_pkg::ALPHA; j++)
                        trie_goto[n*acmc_pkg::ALPHA+j] = '0;
                     fail_of[n] = '0; parent_of[n] = pat_node; hits_at[n] = '0;
                     trie_goto[pat_node*acmc_pkg::ALPHA+it.symbol] = n;
                     pat_node = n;
                  end else pat_dropped = 1;
               end
            end
            if (it.last) begin
               if (!pat_dropped && hits_at[pat_node] != 16'hFFFF)
                  hits_at[pat_node] = hits_at[pat_node] + 1;
               pat_node = 0; pat_dropped = 0;
            end
         end
         acmc_pkg::MODE_BUILD: build_failure_links();
         default: begin
            if (it.symbol >= acmc_pkg::ALPHA) txt_node = 0;
            else begin
               txt_node = trie_goto[txt_node*acmc_pkg::ALPHA+it.symbol];
               v = txt_node; steps = 0;
               while (v != 0 && steps < acmc_pkg::NODES) begin
                  total += hits_at[v];
                  if (total > 16'hFFFF) total = 16'hFFFF;
                  hits_at[v] = '0;
                  v = fail_of[v]; steps++;
               end
            end
            if (it.last) begin
               expected_counts.push_back(total[15:0]);
               total = 0; txt_node = 0;
            end
         end
      endcase
   endtask

   function automatic symbol_item_type mk(logic [1:0] m, int s, int l);
      symbol_item_type it;
      it.mode = m; it.symbol = 5'(s); it.last = 1'(l);
      return it;
   endfunction

   task automatic add_word(int len, int span, bit as_text, bit last_end);
      for (int k = 0; k < len; k++)
         pending_items.push_back(mk(as_text ? acmc_pkg::MODE_TEXT : acmc_pkg::MODE_PATTERN,
            int'($urandom_range(span-1)), int'((k == len-1) && last_end)));
   endtask

   task automatic add_noise();
      pending_items.push_back(mk(2'($urandom_range(3)), int'($urandom_range(31)),
                                 int'($urandom_range(1))));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready) predict_count(
            symbol_item_type'{req_tuser, req_tdata[4:0], req_tlast});
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0 && !send_hold) begin
            req_tvalid <= 1'b1;
            req_tdata <= {3'b000, pending_items[0].symbol};
            req_tuser <= pending_items[0].mode;
            req_tlast <= pending_items[0].last;
            void'(pending_items.pop_front());
            if (!calm && $urandom_range(7) == 0) tx_gap <= $urandom_range(11, 1);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready and monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== expected_counts[0]) begin
                  $display("%0t: match_count mismatch, expected %0d, actual %0d",
                           $time, expected_counts[0], rsp_tdata);
                  errors++;
               end
               void'(expected_counts.pop_front());
            end
         end
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(7) == 0) rx_gap <= $urandom_range(11, 1);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_counts.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int len;
      clear_trie();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: patterns he, she, a, ha and a dropped one; overlap, saturation-free texts
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 7, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 4, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 18, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 7, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 4, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 25, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 31, 1));   // out of range drops
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 18, 0));      // text before build
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 7, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 4, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 0, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_BUILD, 0, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 7, 0));    // pattern after build
      pending_items.push_back(mk(acmc_pkg::MODE_PATTERN, 0, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 25, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 30, 0));      // text out of range
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 18, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 7, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 4, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 0, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 31, 1));
      pending_items.push_back(mk(acmc_pkg::MODE_CLEAR, 0, 0));
      pending_items.push_back(mk(acmc_pkg::MODE_TEXT, 7, 1));
      wait_drained();

      // sender held while the queue fills, then long receiver hold while sender sends
      send_hold = 1;
      for (int r = 0; r < 20; r++) add_word(3, 3, 0, 1);
      pending_items.push_back(mk(acmc_pkg::MODE_BUILD, 0, 0));
      for (int r = 0; r < 12; r++) add_word(2, 3, 1, 1);
      rx_hold_cycles = 600;
      send_hold = 0;
      wait_drained();

      // random sessions: clear, patterns, optional build, texts, with some noise
      for (int s = 0; s < 14; s++) begin
         pending_items.push_back(mk(acmc_pkg::MODE_CLEAR, int'($urandom_range(31)),
                                    int'($urandom_range(1))));
         for (int p = $urandom_range(6, 1); p > 0; p--) add_word($urandom_range(4, 1), 4, 0, 1);
         if ($urandom_range(3) != 0) pending_items.push_back(mk(acmc_pkg::MODE_BUILD, 0, 0));
         for (int t = $urandom_range(4, 1); t > 0; t--) begin
            len = $urandom_range(8, 1);
            add_word(len, 4, 1, 1);
         end
         add_word(2, 26, 0, 1);
         add_word(3, 26, 1, 1);
         if ($urandom_range(2) == 0) add_noise();
         pending_items.push_back(mk(acmc_pkg::MODE_TEXT, int'($urandom_range(31)), 1));
      end
      wait_drained();

      calm = 1;
      pending_items.push_back(mk(acmc_pkg::MODE_CLEAR, 0, 0));
      for (int p = 0; p < 5; p++) add_word(2, 2, 0, 1);
      pending_items.push_back(mk(acmc_pkg::MODE_BUILD, 0, 0));
      for (int t = 0; t < 6; t++) add_word(5, 2, 1, 1);
      wait_drained();

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
